>>> rtl/u8fold_pkg.sv
// ----------------------------------------------------------------------------
// u8fold_pkg
// Shared types, constants and the glyph fold function for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8fold_pkg;

    // Default sizes
    localparam int MAX_TEXT_LEN_DEF = 64;
    localparam int CMD_Q_DEPTH_DEF  = 2;

    // Font slot codes
    localparam logic [6:0] GLYPH_QMARK = 7'h3F;
    localparam logic [6:0] GLYPH_TILDE = 7'h7E;
    localparam logic [6:0] GLYPH_LBRACE = 7'h7B;
    localparam logic [6:0] GLYPH_RBRACE = 7'h7D;
    localparam logic [6:0] GLYPH_BTICK = 7'h60;
    localparam logic [6:0] GLYPH_LOW_O = 7'h6F;

    // Special codepoints
    localparam logic [20:0] CP_ARROW_RIGHT = 21'h02192;
    localparam logic [20:0] CP_ARROW_UP    = 21'h02191;
    localparam logic [20:0] CP_ARROW_DOWN  = 21'h02193;
    localparam logic [20:0] CP_BULLET      = 21'h02022;
    localparam logic [20:0] CP_DEGREE      = 21'h000B0;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [6:0] glyph_code;
        logic       is_end;
        logic [5:0] text_length;
    } result_t;

    // Work command from the decoder to the result sequencer:
    // q_count question marks, then an optional glyph, then an optional end.
    typedef struct packed {
        logic [1:0] q_count;
        logic       has_glyph;
        logic       has_end;
        logic [6:0] code;
    } cmd_t;

    // Kind of result the sequencer produces this cycle
    typedef enum logic [1:0] {
        KIND_QMARK,
        KIND_GLYPH,
        KIND_END
    } kind_t;

    // Fold a codepoint to a 7-bit font slot
    function automatic logic [6:0] fold_to_slot(input logic [20:0] cp);
        logic       latin;
        logic [7:0] lo;
        logic [7:0] up;
        logic [6:0] slot;
        latin = (cp[20:8] == 13'd0);
        lo    = cp[7:0];
        up    = (lo >= 8'hE0) ? (lo - 8'h20) : lo;
        slot  = GLYPH_QMARK;
        if (cp == CP_ARROW_RIGHT) begin
            slot = GLYPH_TILDE;
        end
        else if (cp == CP_ARROW_UP) begin
            slot = GLYPH_LBRACE;
        end
        else if (cp == CP_ARROW_DOWN) begin
            slot = GLYPH_RBRACE;
        end
        else if (cp == CP_BULLET) begin
            slot = GLYPH_BTICK;
        end
        else if (cp == CP_DEGREE) begin
            slot = GLYPH_LOW_O;
        end
        else if (latin && lo >= 8'h61 && lo <= 8'h7A) begin
            slot = 7'(lo - 8'h20);
        end
        else if (latin && lo >= 8'h20 && lo <= 8'h7E) begin
            slot = lo[6:0];
        end
        else if (latin) begin
            // accented Latin-1 letters drop their accent
            if (up >= 8'hC0 && up <= 8'hC5)      slot = 7'h41;
            else if (up >= 8'hC8 && up <= 8'hCB) slot = 7'h45;
            else if (up >= 8'hCC && up <= 8'hCF) slot = 7'h49;
            else if (up >= 8'hD2 && up <= 8'hD6) slot = 7'h4F;
            else if (up >= 8'hD9 && up <= 8'hDC) slot = 7'h55;
            else if (up == 8'hD1)                slot = 7'h4E;
            else if (up == 8'hC7)                slot = 7'h43;
            else                                 slot = GLYPH_QMARK;
        end
        return slot;
    endfunction

endpackage

>>> rtl/u8fold_front.sv
// ----------------------------------------------------------------------------
// u8fold_front
// Accepts bytes, tracks the open UTF-8 sequence and issues work commands.
// ----------------------------------------------------------------------------
module u8fold_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u8fold_pkg::in_item_t item,
    input  logic               q_full,
    output logic               full,
    output logic               cmd_push,
    output u8fold_pkg::cmd_t   cmd
);
    import u8fold_pkg::*;

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  needed_reg, needed_next;
    logic [1:0]  held_reg, held_next;

    logic        accept;
    logic [7:0]  b;
    logic [20:0] merged;
    cmd_t        cmd_c;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign b      = item.data_byte;
    assign merged = {partial_reg[14:0], b[5:0]};

    // Decode one item into a command and the next sequence state
    always_comb
    begin
        partial_next    = partial_reg;
        needed_next     = needed_reg;
        held_next       = held_reg;
        cmd_c.q_count   = 2'd0;
        cmd_c.has_glyph = 1'b0;
        cmd_c.has_end   = 1'b0;
        cmd_c.code      = GLYPH_QMARK;

        if (item.end_of_text) begin
            // flush held bytes, then end the text
            cmd_c.q_count = held_reg;
            cmd_c.has_end = 1'b1;
            partial_next  = '0;
            needed_next   = 2'd0;
            held_next     = 2'd0;
        end
        else if (needed_reg != 2'd0 && b[7:6] == 2'b10) begin
            // continuation byte
            needed_next = needed_reg - 2'd1;
            if (needed_reg == 2'd1) begin
                cmd_c.has_glyph = 1'b1;
                cmd_c.code      = fold_to_slot(merged);
                partial_next    = '0;
                held_next       = 2'd0;
            end
            else begin
                partial_next = merged;
                held_next    = held_reg + 2'd1;
            end
        end
        else begin
            // broken sequence flushes, then the byte starts afresh
            cmd_c.q_count = (needed_reg != 2'd0) ? held_reg : 2'd0;
            partial_next  = '0;
            needed_next   = 2'd0;
            held_next     = 2'd0;
            if (b[7] == 1'b0) begin
                cmd_c.has_glyph = 1'b1;
                cmd_c.code      = fold_to_slot({13'd0, b});
            end
            else if (b[7:5] == 3'b110) begin
                partial_next = {16'd0, b[4:0]};
                needed_next  = 2'd1;
                held_next    = 2'd1;
            end
            else if (b[7:4] == 4'b1110) begin
                partial_next = {17'd0, b[3:0]};
                needed_next  = 2'd2;
                held_next    = 2'd1;
            end
            else if (b[7:3] == 5'b11110) begin
                partial_next = {18'd0, b[2:0]};
                needed_next  = 2'd3;
                held_next    = 2'd1;
            end
            else begin
                cmd_c.has_glyph = 1'b1;
                cmd_c.code      = GLYPH_QMARK;
            end
        end
    end

    assign cmd      = cmd_c;
    assign cmd_push = accept && (cmd_c.q_count != 2'd0 || cmd_c.has_glyph || cmd_c.has_end);

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            partial_reg <= '0;
            needed_reg  <= 2'd0;
            held_reg    <= 2'd0;
        end
        else if (accept) begin
            partial_reg <= partial_next;
            needed_reg  <= needed_next;
            held_reg    <= held_next;
        end
    end

endmodule

>>> rtl/u8fold_cmd_q.sv
// ----------------------------------------------------------------------------
// u8fold_cmd_q
// Short command queue between the decoder and the result sequencer.
// ----------------------------------------------------------------------------
module u8fold_cmd_q #(
    parameter int DEPTH = u8fold_pkg::CMD_Q_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  u8fold_pkg::cmd_t wr_cmd,
    output logic             q_full,
    input  logic             rd_en,
    output logic             q_valid,
    output u8fold_pkg::cmd_t rd_cmd
);
    import u8fold_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_cmd  = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_rd) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> rtl/u8fold_back.sv
// ----------------------------------------------------------------------------
// u8fold_back
// Expands commands into result items, counts glyphs and drives the output.
// ----------------------------------------------------------------------------
module u8fold_back #(
    parameter int MAX_TEXT_LEN = u8fold_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  u8fold_pkg::cmd_t  head,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output u8fold_pkg::result_t result
);
    import u8fold_pkg::*;

    localparam int CW = $clog2(MAX_TEXT_LEN);

    logic [2:0]    idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    kind_t         kind;
    logic [2:0]    len;
    logic          last;
    logic          slot_free;
    logic          step;
    logic          sat;
    logic [CW+5:0] cnt_ext;

    assign slot_free = !out_valid_reg || pop;
    assign step      = q_valid && slot_free;
    assign len       = {1'b0, head.q_count} + {2'd0, head.has_glyph} + {2'd0, head.has_end};
    assign last      = (idx_reg + 3'd1 == len);
    assign q_pop     = step && last;
    assign sat       = ({1'b0, cnt_reg} + 1'b1) >= (CW + 1)'(MAX_TEXT_LEN);
    assign cnt_ext   = {6'd0, cnt_reg};

    // Which result this step of the command yields
    always_comb
    begin
        if (idx_reg < {1'b0, head.q_count}) begin
            kind = KIND_QMARK;
        end
        else if (idx_reg == {1'b0, head.q_count} && head.has_glyph) begin
            kind = KIND_GLYPH;
        end
        else begin
            kind = KIND_END;
        end
    end

    // Result generation and glyph count
    always_comb
    begin
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (step) begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
            case (kind)
                KIND_QMARK, KIND_GLYPH:
                begin
                    // glyphs past the text limit are dropped
                    if (!sat) begin
                        cnt_next             = cnt_reg + 1'b1;
                        out_next.glyph_code  = (kind == KIND_QMARK) ? GLYPH_QMARK : head.code;
                        out_next.is_end      = 1'b0;
                        out_next.text_length = 6'd0;
                        out_valid_next       = 1'b1;
                    end
                end
                KIND_END:
                begin
                    cnt_next             = '0;
                    out_next.glyph_code  = 7'd0;
                    out_next.is_end      = 1'b1;
                    out_next.text_length = cnt_ext[5:0];
                    out_valid_next       = 1'b1;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !pop;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

>>> rtl/utf8_decode_fold_to_font.sv
// An accepted item's command is registered in the command queue, its results in
// the output slot. Throughput: one byte per cycle while the queue is not full;
// an item with k results (up to four) holds the sequencer until all are issued,
// a glyph dropped at the text limit still takes a sequencer step, and a two-entry
// queue absorbs this. Reset: async, active low; clears sequence, count and queue.
// ----------------------------------------------------------------------------
// utf8_decode_fold_to_font
// UTF-8 byte stream decoder that folds each character to a font slot code.
// ----------------------------------------------------------------------------
module utf8_decode_fold_to_font #(
    parameter int MAX_TEXT_LEN = u8fold_pkg::MAX_TEXT_LEN_DEF,
    parameter int CMD_Q_DEPTH  = u8fold_pkg::CMD_Q_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  u8fold_pkg::in_item_t item,
    output logic                empty,
    input  logic                pop,
    output u8fold_pkg::result_t result
);
    import u8fold_pkg::*;

    logic cmd_push;
    cmd_t cmd_in;
    logic q_full;
    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    // Decoder
    u8fold_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // Command queue
    u8fold_cmd_q #(
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd_in),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_cmd  (q_head)
    );

    // Result sequencer
    u8fold_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

`ifndef SYNTHESIS
    // end result carries no glyph
    a_end_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_end) |-> (result.glyph_code == 7'd0))
        else $error("end item with nonzero glyph code");

    // glyph results carry no length
    a_glyph_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.is_end) |-> (result.text_length == 6'd0))
        else $error("glyph item with nonzero length");

    // a full queue always has work for the sequencer
    a_full_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_valid)
        else $error("queue full while sequencer sees no command");

    // a free output slot with pending work gets filled or the work is dropped
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && empty && q_pop) |=> (!empty || $past(q_head.has_end) == 1'b0))
        else $error("end item lost by sequencer");
`endif

endmodule
